FILE: sv/pff_pkg.sv
package pff_pkg;

	// Framing limits and header layout.
	localparam int unsigned MAX_PAYLOAD  = 8192;
	localparam int unsigned MTU_OVERHEAD = 17;
	localparam int unsigned HDR_LEN      = 14;
	localparam int unsigned HDR_IDX_W    = 4;
	localparam int unsigned MTU_RESET    = 23;

	// Width of the divider and its step counter.
	localparam int unsigned DIV_W     = 16;
	localparam int unsigned DIV_CNT_W = 4;

	// Header constant bytes and flag bits.
	localparam logic [7:0] HDR_MAGIC0  = 8'h46;
	localparam logic [7:0] HDR_MAGIC1  = 8'h55;
	localparam logic [7:0] HDR_VERSION = 8'h01;
	localparam int unsigned FLAG_FIRST_BIT = 0;
	localparam int unsigned FLAG_FINAL_BIT = 1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_LARGE = 2'd1,
		ST_FRAG_ERR  = 2'd2,
		ST_NOT_OPEN  = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_HDR
	} state_t;

	// Input operation codes.
	typedef enum logic {
		OP_BEGIN = 1'b0,
		OP_BYTE  = 1'b1
	} op_t;

endpackage

FILE: sv/payload_fragment_framer.sv
// Payload fragment framer. A begin item (op 0) opens a transfer: the chunk
// capacity is link_mtu minus 17, the frame count is the payload length divided
// by that capacity, rounded up and at least one, and the 14-byte header of the
// first frame follows. Each byte item (op 1) passes its byte through; when it
// fills a chunk and payload remains, the next frame's header follows it. Each
// result carries one frame byte, or a status code with no byte, and last marks
// the final result of an item. A begin item that opens a transfer passes
// through the accepting cycle, 16 steps of the radix-2 divider, a step to
// take the quotient and then the header bytes, one per cycle while out_stall
// is low. A rejected begin item or a byte item gives a single result, which
// the next frame's header follows when the byte fills a chunk. The output
// register holds a result while out_stall is high, and the block takes no
// item until the previous one has produced all of its results. link_mtu is
// sampled at begin items only.
module payload_fragment_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        link_mtu_we,
	input  logic [15:0] link_mtu_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [31:0] xfer_id,
	input  logic [15:0] payload_length,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        has_byte,
	output logic [7:0]  out_byte,
	output logic        frame_end,
	output logic        last
);
	import pff_pkg::*;

	// Control registers.
	state_t                state_q, state_d;
	logic                  open_q, open_d;
	logic                  out_valid_q, out_valid_d;
	logic [15:0]           link_mtu_q;
	logic [HDR_IDX_W-1:0]  hdr_idx_q, hdr_idx_d;

	// Transfer registers.
	logic [31:0]  current_id_q, current_id_d;
	logic [15:0]  total_bytes_q, total_bytes_d;
	logic [15:0]  frame_count_q, frame_count_d;
	logic [15:0]  frame_index_q, frame_index_d;
	logic [15:0]  chunk_cap_q, chunk_cap_d;
	logic [15:0]  left_chunk_q, left_chunk_d;
	logic [15:0]  left_payload_q, left_payload_d;
	logic         hdr_only_q, hdr_only_d;

	// Output register.
	status_t      status_q, status_d;
	logic         has_byte_q, has_byte_d;
	logic [7:0]   out_byte_q, out_byte_d;
	logic         frame_end_q, frame_end_d;
	logic         last_q, last_d;

	// Divider hookup.
	logic         div_start;
	logic         div_done;
	logic [15:0]  div_quo;
	logic [15:0]  div_rem;
	logic [15:0]  mtu_cap;

	logic         out_free;
	logic         in_fire;
	logic [7:0]   hdr_byte;
	logic [7:0]   hdr_flags;

	pff_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (payload_length),
		.divisor   (mtu_cap),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign mtu_cap  = link_mtu_q - 16'(MTU_OVERHEAD);
	assign out_free = ~out_valid_q | ~out_stall;
	assign in_stall = ~((state_q == S_IDLE) & out_free);
	assign in_fire  = in_valid & ~in_stall;

	// Flags of the frame whose header is going out.
	always_comb begin
		hdr_flags = '0;
		hdr_flags[FLAG_FIRST_BIT] = (frame_index_q == 16'd0);
		hdr_flags[FLAG_FINAL_BIT] = ({1'b0, frame_index_q} + 17'd1 == {1'b0, frame_count_q});
	end

	// Header byte selected by position, all multi-byte fields little-endian.
	always_comb begin
		unique case (hdr_idx_q)
			4'd0:    hdr_byte = HDR_MAGIC0;
			4'd1:    hdr_byte = HDR_MAGIC1;
			4'd2:    hdr_byte = HDR_VERSION;
			4'd3:    hdr_byte = hdr_flags;
			4'd4:    hdr_byte = current_id_q[7:0];
			4'd5:    hdr_byte = current_id_q[15:8];
			4'd6:    hdr_byte = current_id_q[23:16];
			4'd7:    hdr_byte = current_id_q[31:24];
			4'd8:    hdr_byte = frame_index_q[7:0];
			4'd9:    hdr_byte = frame_index_q[15:8];
			4'd10:   hdr_byte = frame_count_q[7:0];
			4'd11:   hdr_byte = frame_count_q[15:8];
			4'd12:   hdr_byte = total_bytes_q[7:0];
			4'd13:   hdr_byte = total_bytes_q[15:8];
			default: hdr_byte = '0;
		endcase
	end

	// Sequencer: next state, transfer bookkeeping and the next result.
	always_comb begin
		logic [15:0] chunk_dec;
		logic [15:0] payload_dec;
		logic [15:0] count_tmp;
		logic        load;

		chunk_dec   = (left_chunk_q != 16'd0) ? left_chunk_q - 16'd1 : left_chunk_q;
		payload_dec = (left_payload_q != 16'd0) ? left_payload_q - 16'd1 : left_payload_q;
		count_tmp   = div_quo + {15'd0, (div_rem != 16'd0)};
		load        = 1'b0;

		state_d        = state_q;
		open_d         = open_q;
		hdr_idx_d      = hdr_idx_q;
		current_id_d   = current_id_q;
		total_bytes_d  = total_bytes_q;
		frame_count_d  = frame_count_q;
		frame_index_d  = frame_index_q;
		chunk_cap_d    = chunk_cap_q;
		left_chunk_d   = left_chunk_q;
		left_payload_d = left_payload_q;
		hdr_only_d     = hdr_only_q;
		status_d       = status_q;
		has_byte_d     = has_byte_q;
		out_byte_d     = out_byte_q;
		frame_end_d    = frame_end_q;
		last_d         = last_q;
		div_start      = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (op == OP_BEGIN) begin
						if ({16'd0, payload_length} > 32'(MAX_PAYLOAD)) begin
							open_d = 1'b0;
							load = 1'b1;
							status_d = ST_TOO_LARGE;
							has_byte_d = 1'b0;
							out_byte_d = '0;
							frame_end_d = 1'b0;
							last_d = 1'b1;
						end else if (link_mtu_q <= 16'(MTU_OVERHEAD)) begin
							open_d = 1'b0;
							load = 1'b1;
							status_d = ST_FRAG_ERR;
							has_byte_d = 1'b0;
							out_byte_d = '0;
							frame_end_d = 1'b0;
							last_d = 1'b1;
						end else begin
							div_start = 1'b1;
							open_d = 1'b0;
							current_id_d = xfer_id;
							total_bytes_d = payload_length;
							chunk_cap_d = mtu_cap;
							left_payload_d = payload_length;
							left_chunk_d = (mtu_cap < payload_length) ? mtu_cap
								: payload_length;
							frame_index_d = '0;
							hdr_only_d = (payload_length == 16'd0);
							state_d = S_DIV;
						end
					end else if (!open_q) begin
						load = 1'b1;
						status_d = ST_NOT_OPEN;
						has_byte_d = 1'b0;
						out_byte_d = '0;
						frame_end_d = 1'b0;
						last_d = 1'b1;
					end else begin
						load = 1'b1;
						status_d = ST_OK;
						has_byte_d = 1'b1;
						out_byte_d = data_byte;
						left_chunk_d = chunk_dec;
						left_payload_d = payload_dec;
						if (payload_dec == 16'd0) begin
							// Final byte of the payload closes the transfer.
							frame_end_d = 1'b1;
							last_d = 1'b1;
							open_d = 1'b0;
						end else if (chunk_dec == 16'd0) begin
							// Chunk full: the next frame's header follows.
							frame_end_d = 1'b1;
							last_d = 1'b0;
							frame_index_d = frame_index_q + 16'd1;
							left_chunk_d = (chunk_cap_q < payload_dec) ? chunk_cap_q
								: payload_dec;
							hdr_only_d = 1'b0;
							hdr_idx_d = '0;
							state_d = S_HDR;
						end else begin
							frame_end_d = 1'b0;
							last_d = 1'b1;
						end
					end
				end
			end
			S_DIV: begin
				if (div_done) begin
					frame_count_d = (count_tmp == 16'd0) ? 16'd1 : count_tmp;
					open_d = ~hdr_only_q;
					hdr_idx_d = '0;
					state_d = S_HDR;
				end
			end
			S_HDR: begin
				if (out_free) begin
					load = 1'b1;
					status_d = ST_OK;
					has_byte_d = 1'b1;
					out_byte_d = hdr_byte;
					if (hdr_idx_q == HDR_IDX_W'(HDR_LEN - 1)) begin
						frame_end_d = hdr_only_q;
						last_d = 1'b1;
						state_d = S_IDLE;
					end else begin
						frame_end_d = 1'b0;
						last_d = 1'b0;
						hdr_idx_d = hdr_idx_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// The output register holds until its result is taken.
		if (load) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
			hdr_idx_q   <= '0;
			link_mtu_q  <= 16'(MTU_RESET);
		end else begin
			state_q     <= state_d;
			open_q      <= open_d;
			out_valid_q <= out_valid_d;
			hdr_idx_q   <= hdr_idx_d;
			if (link_mtu_we) begin
				link_mtu_q <= link_mtu_wdata;
			end
		end
	end

	// Transfer and result payload.
	always_ff @(posedge clk) begin
		current_id_q   <= current_id_d;
		total_bytes_q  <= total_bytes_d;
		frame_count_q  <= frame_count_d;
		frame_index_q  <= frame_index_d;
		chunk_cap_q    <= chunk_cap_d;
		left_chunk_q   <= left_chunk_d;
		left_payload_q <= left_payload_d;
		hdr_only_q     <= hdr_only_d;
		status_q       <= status_d;
		has_byte_q     <= has_byte_d;
		out_byte_q     <= out_byte_d;
		frame_end_q    <= frame_end_d;
		last_q         <= last_d;
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign has_byte  = has_byte_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign last      = last_q;

endmodule

FILE: sv/pff_div.sv
module pff_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pff_pkg::DIV_W-1:0]  dividend,
	input  logic [pff_pkg::DIV_W-1:0]  divisor,
	output logic                       done,
	output logic [pff_pkg::DIV_W-1:0]  quotient,
	output logic [pff_pkg::DIV_W-1:0]  remainder
);
	import pff_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]      rem_q;
	logic [DIV_W-1:0]      quo_q;
	logic [DIV_W-1:0]      dvs_q;
	logic [DIV_W:0]        shifted;
	logic [DIV_W:0]        trial;
	logic                  fits;

	// One restoring step: shift in the next dividend bit and try a subtract.
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign fits    = ~trial[DIV_W];

	// Control: busy for one step per quotient bit, done pulses after the last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the quotient register starts out holding the dividend.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: tb/sv/tb_payload_fragment_framer.sv
`timescale 1ns / 1ps

module tb_payload_fragment_framer;
	import pff_pkg::*;

	// One input item as the driver presents it.
	typedef struct packed {
		op_t         op;
		logic [31:0] xfer_id;
		logic [15:0] len;
		logic [7:0]  data;
	} fragment_item_t;

	// One result item as the block should produce it.
	typedef struct packed {
		status_t    status;
		logic       has_byte;
		logic [7:0] out_byte;
		logic       frame_end;
		logic       last;
	} frame_result_t;

	logic        clk;
	logic        arst_n;
	logic        link_mtu_we;
	logic [15:0] link_mtu_wdata;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [31:0] xfer_id;
	logic [15:0] payload_length;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic        has_byte;
	logic [7:0]  out_byte;
	logic        frame_end;
	logic        last;

	fragment_item_t pending_items[$];
	frame_result_t  expected_frame_bytes[$];
	fragment_item_t next_item;
	fragment_item_t accepted_item;
	frame_result_t  oldest_result;
	logic           item_taken;
	int unsigned    send_idle_pct;
	int unsigned    recv_idle_pct;
	int unsigned    mismatch_count = 0;

	// Shadow of the framer: the MTU register and the open transfer.
	logic [15:0] mtu_copy;
	logic        xfer_open;
	logic [31:0] cur_id;
	logic [15:0] total_len;
	logic [15:0] n_frames;
	logic [15:0] frame_idx;
	logic [15:0] chunk_cap;
	logic [15:0] chunk_left;
	logic [15:0] payload_left;

	payload_fragment_framer u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.link_mtu_we    (link_mtu_we),
		.link_mtu_wdata (link_mtu_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.xfer_id        (xfer_id),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.has_byte       (has_byte),
		.out_byte       (out_byte),
		.frame_end      (frame_end),
		.last           (last)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#10_000_000;
		$display("FAIL payload_fragment_framer");
		$finish;
	end

	task automatic push_result(status_t st, logic has, logic [7:0] b, logic fe);
		frame_result_t r;
		r = '{st, has, b, fe, 1'b0};
		expected_frame_bytes = {expected_frame_bytes, r};
	endtask

	// Queues the 14 header bytes of the current frame.
	task automatic push_header(logic header_only);
		logic [7:0] hdr [HDR_LEN];
		logic [7:0] flags;
		flags = 8'h00;
		if (frame_idx == 16'd0) begin
			flags[FLAG_FIRST_BIT] = 1'b1;
		end
		if ({16'd0, frame_idx} + 32'd1 == {16'd0, n_frames}) begin
			flags[FLAG_FINAL_BIT] = 1'b1;
		end
		hdr[0]  = HDR_MAGIC0;
		hdr[1]  = HDR_MAGIC1;
		hdr[2]  = HDR_VERSION;
		hdr[3]  = flags;
		hdr[4]  = cur_id[7:0];
		hdr[5]  = cur_id[15:8];
		hdr[6]  = cur_id[23:16];
		hdr[7]  = cur_id[31:24];
		hdr[8]  = frame_idx[7:0];
		hdr[9]  = frame_idx[15:8];
		hdr[10] = n_frames[7:0];
		hdr[11] = n_frames[15:8];
		hdr[12] = total_len[7:0];
		hdr[13] = total_len[15:8];
		for (int i = 0; i < HDR_LEN; i++) begin
			push_result(ST_OK, 1'b1, hdr[i], header_only && (i == HDR_LEN - 1));
		end
	endtask

	// Works out every frame byte that one accepted item causes.
	task automatic predict_frames(fragment_item_t it);
		int unsigned   cap;
		int unsigned   cnt;
		frame_result_t tail;
		if (it.op == OP_BEGIN) begin
			if (it.len > MAX_PAYLOAD) begin
				xfer_open = 1'b0;
				push_result(ST_TOO_LARGE, 1'b0, 8'h00, 1'b0);
			end else if (mtu_copy <= MTU_OVERHEAD) begin
				xfer_open = 1'b0;
				push_result(ST_FRAG_ERR, 1'b0, 8'h00, 1'b0);
			end else begin
				cap = mtu_copy - MTU_OVERHEAD;
				cnt = (it.len + cap - 1) / cap;
				if (cnt == 0) begin
					cnt = 1;
				end
				cur_id       = it.xfer_id;
				total_len    = it.len;
				n_frames     = cnt[15:0];
				frame_idx    = 16'd0;
				chunk_cap    = cap[15:0];
				payload_left = it.len;
				chunk_left   = (chunk_cap < it.len) ? chunk_cap : it.len;
				push_header(it.len == 16'd0);
				xfer_open = (it.len != 16'd0);
			end
		end else if (!xfer_open) begin
			push_result(ST_NOT_OPEN, 1'b0, 8'h00, 1'b0);
		end else begin
			if (chunk_left != 16'd0) begin
				chunk_left = chunk_left - 16'd1;
			end
			if (payload_left != 16'd0) begin
				payload_left = payload_left - 16'd1;
			end
			if (payload_left == 16'd0) begin
				push_result(ST_OK, 1'b1, it.data, 1'b1);
				xfer_open = 1'b0;
			end else if (chunk_left == 16'd0) begin
				// The chunk is full: the next frame's header follows at once.
				push_result(ST_OK, 1'b1, it.data, 1'b1);
				frame_idx  = frame_idx + 16'd1;
				chunk_left = (chunk_cap < payload_left) ? chunk_cap : payload_left;
				push_header(1'b0);
			end else begin
				push_result(ST_OK, 1'b1, it.data, 1'b0);
			end
		end
		tail = expected_frame_bytes[expected_frame_bytes.size() - 1];
		tail.last = 1'b1;
		expected_frame_bytes[expected_frame_bytes.size() - 1] = tail;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Unused fields carry random junk so that the block is seen to ignore them.
	task automatic queue_begin(logic [31:0] id, logic [15:0] len);
		fragment_item_t it;
		it = '{OP_BEGIN, id, len, 8'($urandom_range(0, 255))};
		pending_items = {pending_items, it};
	endtask

	task automatic queue_byte(logic [7:0] b);
		fragment_item_t it;
		it = '{OP_BYTE, $urandom(), 16'($urandom_range(0, 65535)), b};
		pending_items = {pending_items, it};
	endtask

	// Mostly whole transfers with random content, plus broken ones and noise.
	task automatic queue_random_traffic(int unsigned n);
		int unsigned made;
		int unsigned pick;
		int unsigned len;
		int unsigned nb;
		// A few bytes first, which continue any transfer left from the last phase.
		nb = $urandom_range(0, 3);
		repeat (nb) queue_byte(8'($urandom_range(0, 255)));
		made = nb;
		while (made < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60) :
					$urandom_range(0, 20);
				queue_begin($urandom(), 16'(len));
				repeat (len) queue_byte(8'($urandom_range(0, 255)));
				made += len + 1;
			end else if (pick < 80) begin
				len = $urandom_range(1, 20);
				nb = $urandom_range(0, len + 2);
				queue_begin($urandom(), 16'(len));
				repeat (nb) queue_byte(8'($urandom_range(0, 255)));
				made += nb + 1;
			end else if (pick < 88) begin
				queue_byte(8'($urandom_range(0, 255)));
				made += 1;
			end else if (pick < 95) begin
				queue_begin($urandom(), 16'($urandom_range(MAX_PAYLOAD + 1, 65535)));
				made += 1;
			end else begin
				// A transfer of up to MAX_PAYLOAD bytes that is begun and then abandoned.
				nb = $urandom_range(0, 3);
				queue_begin($urandom(), 16'($urandom_range(0, MAX_PAYLOAD)));
				repeat (nb) queue_byte(8'($urandom_range(0, 255)));
				made += nb + 1;
			end
		end
	endtask

	// Holds the sender back until the block has delivered every result.
	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || expected_frame_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic write_mtu(logic [15:0] value);
		@(negedge clk);
		link_mtu_we    <= 1'b1;
		link_mtu_wdata <= value;
		@(negedge clk);
		link_mtu_we    <= 1'b0;
	endtask

	// Driver: presents the next pending item and holds it until it is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || item_taken) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_item = pending_items[0];
					pending_items.delete(0);
					in_valid       <= 1'b1;
					op             <= next_item.op;
					xfer_id        <= next_item.xfer_id;
					payload_length <= next_item.len;
					data_byte      <= next_item.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end else begin
			in_valid       <= 1'b0;
			op             <= 1'b0;
			xfer_id        <= 32'd0;
			payload_length <= 16'd0;
			data_byte      <= 8'd0;
			out_stall      <= 1'b0;
		end
	end

	// Monitor: tracks register writes, predicts accepted items, checks results.
	always @(posedge clk) begin
		if (arst_n) begin
			item_taken <= in_valid && !in_stall;
			if (link_mtu_we) begin
				mtu_copy = link_mtu_wdata;
			end
			if (in_valid && !in_stall) begin
				accepted_item = '{op_t'(op), xfer_id, payload_length, data_byte};
				predict_frames(accepted_item);
			end
			if (out_valid && !out_stall) begin
				if (expected_frame_bytes.size() == 0) begin
					$error("result with none expected: status %0d byte 0x%0h", status, out_byte);
					mismatch_count++;
				end else begin
					oldest_result = expected_frame_bytes[0];
					expected_frame_bytes.delete(0);
					check_field("status", oldest_result.status, status);
					check_field("has_byte", oldest_result.has_byte, has_byte);
					check_field("out_byte", oldest_result.out_byte, out_byte);
					check_field("frame_end", oldest_result.frame_end, frame_end);
					check_field("last", oldest_result.last, last);
				end
			end
		end else begin
			// The shadow follows the block's reset state.
			item_taken   <= 1'b0;
			mtu_copy     = 16'(MTU_RESET);
			xfer_open    = 1'b0;
			cur_id       = 32'd0;
			total_len    = 16'd0;
			n_frames     = 16'd0;
			frame_idx    = 16'd0;
			chunk_cap    = 16'd0;
			chunk_left   = 16'd0;
			payload_left = 16'd0;
		end
	end

	// Stimulus sequence.
	initial begin
		arst_n         = 1'b0;
		link_mtu_we    = 1'b0;
		link_mtu_wdata = 16'd0;
		send_idle_pct  = 21;
		recv_idle_pct  = 81;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed cases at the reset MTU, where a chunk holds six bytes.
		queue_byte(8'hA5);
		queue_begin(32'hFFFF_FFFF, 16'd0);
		queue_byte(8'h00);
		queue_begin(32'h0000_0000, 16'(MAX_PAYLOAD + 1));
		queue_begin(32'h0000_0001, 16'hFFFF);
		queue_begin(32'h1234_5678, 16'd8);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h5A);
		queue_byte(8'h3C);
		queue_byte(8'h81);
		queue_byte(8'h7E);
		queue_byte(8'h01);
		queue_byte(8'h80);
		queue_begin(32'hDEAD_BEEF, 16'd3);
		queue_byte(8'h11);
		queue_begin(32'hA5A5_5A5A, 16'd2);
		queue_byte(8'h22);
		queue_byte(8'h33);
		queue_byte(8'h44);
		queue_begin(32'h0000_0002, 16'(MAX_PAYLOAD));
		queue_byte(8'h55);
		wait_idle();

		// An MTU change leaves the open transfer on its old chunk size.
		write_mtu(16'hFFFF);
		queue_byte(8'h66);
		wait_idle();

		// MTU at and below the overhead; the size check wins over it.
		write_mtu(16'(MTU_OVERHEAD));
		queue_begin(32'h0000_0003, 16'd5);
		queue_begin(32'h0000_0004, 16'd9000);
		queue_byte(8'h77);
		wait_idle();
		write_mtu(16'd0);
		queue_begin(32'h0000_0005, 16'd0);
		wait_idle();

		// Random traffic over several MTU settings and idling patterns.
		write_mtu(16'(MTU_OVERHEAD + 1));
		queue_random_traffic(70);
		wait_idle();
		write_mtu(16'(MTU_RESET));
		queue_random_traffic(30);
		wait_idle();

		send_idle_pct = 81;
		recv_idle_pct = 21;
		write_mtu(16'hFFFF);
		queue_random_traffic(45);
		wait_idle();
		write_mtu(16'd24);
		queue_random_traffic(45);
		wait_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_mtu(16'd20);
		queue_random_traffic(55);
		wait_idle();
		write_mtu(16'd40);
		queue_random_traffic(45);
		wait_idle();

		if (mismatch_count == 0) begin
			$display("PASS payload_fragment_framer");
		end else begin
			$display("FAIL payload_fragment_framer");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/pff_pkg.sv
sv/pff_div.sv
sv/payload_fragment_framer.sv
tb/sv/tb_payload_fragment_framer.sv
